FILE: rtl/cpr_pkg.sv
// Package for the closed polyline resampler: widths, constants, types.
// Used by every module of the block; no dependencies.
package cpr_pkg;

  localparam int CoordW      = 16;
  localparam int StepW       = 16;
  localparam int DeltaW      = 17;
  localparam int SqW         = 36;
  localparam int LenW        = 18;
  localparam int MaxStepsDef = 32;
  localparam logic [StepW-1:0] StepLenReset = 16'd102;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE,
    S_SQR_X,
    S_SQR_Y,
    S_SQRT,
    S_DIV,
    S_SPLIT,
    S_EMIT,
    S_LONE
  } cpr_state_t;

  typedef struct packed {
    logic load_vertex;    // latch input beat
    logic set_first;      // store input beat as first and previous
    logic start_edge;     // latch edge start and delta
    logic edge_sel;       // 0: prev to vertex, 1: vertex back to first
    logic sq_x;
    logic sq_y;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic steps_init;     // clamp step count, load per-axis split
    logic split_step;
    logic emit_init;
    logic emit_adv;       // point taken, advance k
    logic lone;           // output the lone vertex
    logic commit_prev;
  } cpr_cmd_t;

  typedef struct packed {
    logic closes;
    logic have_first;
    logic sqrt_done;
    logic div_done;
    logic split_done;
    logic emit_last;
  } cpr_stat_t;

endpackage

FILE: rtl/cpr_datapath.sv
// Datapath of the closed polyline resampler: vertex store, squared length,
// iterative square root and dividers, and the point generator. Uses cpr_pkg.
module cpr_datapath #(
  parameter int MAX_STEPS = cpr_pkg::MaxStepsDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [cpr_pkg::StepW-1:0]    step_length,
  input  logic [cpr_pkg::CoordW-1:0]   in_x,
  input  logic [cpr_pkg::CoordW-1:0]   in_y,
  input  logic                         in_closes,
  input  cpr_pkg::cpr_cmd_t            cmd,
  output cpr_pkg::cpr_stat_t           stat,
  output logic [cpr_pkg::CoordW-1:0]   pt_x,
  output logic [cpr_pkg::CoordW-1:0]   pt_y,
  output logic                         pt_clip
);
  import cpr_pkg::*;

  localparam int KW       = $clog2(MAX_STEPS + 1);
  localparam int SqrtIter = SqW / 2;
  localparam int SIW      = $clog2(SqrtIter + 1);
  localparam int DIW      = $clog2(LenW + 1);

  logic signed [CoordW-1:0] vx, vy, first_x, first_y, prev_x, prev_y;
  logic                     closes, have_first;
  logic signed [CoordW-1:0] sx, sy;
  logic signed [DeltaW-1:0] dx, dy;
  logic        [SqW-1:0]    sq;
  logic        [SqW-1:0]    rem;
  logic        [LenW-1:0]   root;
  logic        [SIW-1:0]    sqrt_cnt;
  logic        [LenW-1:0]   quo;
  logic        [StepW-1:0]  drem;
  logic        [DIW-1:0]    div_cnt;
  logic        [KW-1:0]     steps, k;
  logic                     clip;
  logic        [DeltaW-1:0] magx, magy;
  logic        [DeltaW-1:0] qdx, qdy;   // |d| / steps
  logic        [KW-1:0]     rdx, rdy;   // |d| % steps
  logic        [DeltaW-1:0] qx, qy;     // floor(k*|d| / steps)
  logic        [KW-1:0]     rx, ry;
  logic        [DeltaW-1:0] ox, oy;

  // edge selection
  logic signed [CoordW-1:0] esx, esy, eex, eey;
  always_comb begin
    if (cmd.edge_sel) begin
      esx = vx; esy = vy; eex = first_x; eey = first_y;
    end else begin
      esx = prev_x; esy = prev_y; eex = vx; eey = vy;
    end
  end

  logic signed [DeltaW-1:0]   dsel;
  logic signed [2*DeltaW-1:0] prod;
  assign dsel = cmd.sq_x ? dx : dy;
  assign prod = dsel * dsel;

  // square root: two bits of the radicand per cycle
  logic [LenW+1:0] trial;
  logic [SqW+1:0]  rem_sh;
  assign rem_sh = {rem, sq[SqW-1 -: 2]};
  assign trial  = {root, 2'b01};

  // divider: restoring, one quotient bit per cycle
  logic [StepW:0] dsh;
  assign dsh = {drem, quo[LenW-1]};

  // per-axis split of |d| by the step count
  logic [KW:0] xsh, ysh;
  assign xsh = {rdx, qdx[DeltaW-1]};
  assign ysh = {rdy, qdy[DeltaW-1]};

  // running remainder of k*|d| / steps
  logic [KW:0] rsx, rsy;
  assign rsx = {1'b0, rx} + {1'b0, rdx};
  assign rsy = {1'b0, ry} + {1'b0, rdy};

  always_ff @(posedge clk) begin
    if (rst) begin
      first_x    <= '0;
      first_y    <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      have_first <= 1'b0;
    end else begin
      if (cmd.set_first) begin
        first_x    <= in_x;
        first_y    <= in_y;
        prev_x     <= in_x;
        prev_y     <= in_y;
        have_first <= 1'b1;
      end
      if (cmd.commit_prev) begin
        prev_x <= vx;
        prev_y <= vy;
        if (closes) have_first <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vertex) begin
      vx     <= in_x;
      vy     <= in_y;
      closes <= in_closes;
    end
    if (cmd.start_edge) begin
      sx <= esx;
      sy <= esy;
      dx <= DeltaW'(eex) - DeltaW'(esx);
      dy <= DeltaW'(eey) - DeltaW'(esy);
    end
    if (cmd.sq_x) sq <= SqW'($unsigned(prod));
    if (cmd.sq_y) sq <= sq + SqW'($unsigned(prod));
    if (cmd.sqrt_init) begin
      rem      <= '0;
      root     <= '0;
      sqrt_cnt <= '0;
    end
    if (cmd.sqrt_step) begin
      sq       <= {sq[SqW-3:0], 2'b00};
      sqrt_cnt <= sqrt_cnt + 1'b1;
      if (rem_sh >= (SqW+2)'(trial)) begin
        rem  <= SqW'(rem_sh - (SqW+2)'(trial));
        root <= {root[LenW-2:0], 1'b1};
      end else begin
        rem  <= SqW'(rem_sh);
        root <= {root[LenW-2:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      quo     <= root;
      drem    <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (dsh >= {1'b0, step_length}) begin
        drem <= StepW'(dsh - {1'b0, step_length});
        quo  <= {quo[LenW-2:0], 1'b1};
      end else begin
        drem <= StepW'(dsh);
        quo  <= {quo[LenW-2:0], 1'b0};
      end
    end
    if (cmd.steps_init) begin
      if (step_length == '0) begin
        if (root == '0) begin
          steps <= KW'(1); clip <= 1'b0;
        end else begin
          steps <= KW'(MAX_STEPS); clip <= 1'b1;
        end
      end else if (quo == '0) begin
        steps <= KW'(1); clip <= 1'b0;
      end else if (quo > LenW'(MAX_STEPS)) begin
        steps <= KW'(MAX_STEPS); clip <= 1'b1;
      end else begin
        steps <= KW'(quo); clip <= 1'b0;
      end
      qdx     <= magx;
      qdy     <= magy;
      rdx     <= '0;
      rdy     <= '0;
      div_cnt <= '0;
    end
    if (cmd.split_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (xsh >= {1'b0, steps}) begin
        rdx <= KW'(xsh - {1'b0, steps});
        qdx <= {qdx[DeltaW-2:0], 1'b1};
      end else begin
        rdx <= KW'(xsh);
        qdx <= {qdx[DeltaW-2:0], 1'b0};
      end
      if (ysh >= {1'b0, steps}) begin
        rdy <= KW'(ysh - {1'b0, steps});
        qdy <= {qdy[DeltaW-2:0], 1'b1};
      end else begin
        rdy <= KW'(ysh);
        qdy <= {qdy[DeltaW-2:0], 1'b0};
      end
    end
    if (cmd.emit_init) begin
      k  <= '0;
      qx <= '0;
      qy <= '0;
      rx <= '0;
      ry <= '0;
    end
    if (cmd.emit_adv) begin
      k <= k + 1'b1;
      if (rsx >= {1'b0, steps}) begin
        rx <= KW'(rsx - {1'b0, steps});
        qx <= qx + qdx + DeltaW'(1);
      end else begin
        rx <= KW'(rsx);
        qx <= qx + qdx;
      end
      if (rsy >= {1'b0, steps}) begin
        ry <= KW'(rsy - {1'b0, steps});
        qy <= qy + qdy + DeltaW'(1);
      end else begin
        ry <= KW'(rsy);
        qy <= qy + qdy;
      end
    end
  end

  assign magx = dx[DeltaW-1] ? DeltaW'(-dx) : DeltaW'(dx);
  assign magy = dy[DeltaW-1] ? DeltaW'(-dy) : DeltaW'(dy);

  assign ox = dx[DeltaW-1] ? DeltaW'(-qx) : qx;
  assign oy = dy[DeltaW-1] ? DeltaW'(-qy) : qy;

  assign pt_x    = cmd.lone ? vx : sx + ox[CoordW-1:0];
  assign pt_y    = cmd.lone ? vy : sy + oy[CoordW-1:0];
  assign pt_clip = cmd.lone ? 1'b0 : clip;

  assign stat.closes     = closes;
  assign stat.have_first = have_first;
  assign stat.sqrt_done  = (sqrt_cnt == SIW'(SqrtIter));
  assign stat.div_done   = (div_cnt == DIW'(LenW));
  assign stat.split_done = (div_cnt == DIW'(DeltaW));
  assign stat.emit_last  = (k == steps - 1'b1);

endmodule

FILE: rtl/cpr_ctrl.sv
// Controller of the closed polyline resampler: sequences one vertex through
// the datapath and drives the output handshake. Uses cpr_pkg.
module cpr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               s_closes,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic               m_tlast,
  output cpr_pkg::cpr_cmd_t  cmd,
  input  cpr_pkg::cpr_stat_t stat
);
  import cpr_pkg::*;

  cpr_state_t state, state_next;
  logic       edge_sel, edge_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      edge_sel <= 1'b0;
    end else begin
      state    <= state_next;
      edge_sel <= edge_sel_next;
    end
  end

  always_comb begin
    state_next    = state;
    edge_sel_next = edge_sel;
    cmd           = '0;
    cmd.edge_sel  = edge_sel;
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    m_tlast       = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_vertex = 1'b1;
          if (!stat.have_first) begin
            if (s_closes) state_next = S_LONE;
            else cmd.set_first = 1'b1;
          end else begin
            edge_sel_next = 1'b0;
            state_next    = S_EDGE;
          end
        end
      end
      S_EDGE: begin
        cmd.start_edge = 1'b1;
        state_next     = S_SQR_X;
      end
      S_SQR_X: begin
        cmd.sq_x   = 1'b1;
        state_next = S_SQR_Y;
      end
      S_SQR_Y: begin
        cmd.sq_y      = 1'b1;
        cmd.sqrt_init = 1'b1;
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.steps_init = 1'b1;
          state_next     = S_SPLIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_SPLIT: begin
        if (stat.split_done) begin
          cmd.emit_init = 1'b1;
          state_next    = S_EMIT;
        end else begin
          cmd.split_step = 1'b1;
        end
      end
      S_EMIT: begin
        m_tvalid = 1'b1;
        m_tlast  = stat.emit_last && (edge_sel || !stat.closes);
        if (m_tready) begin
          cmd.emit_adv = 1'b1;
          if (stat.emit_last) begin
            if (!edge_sel && stat.closes) begin
              edge_sel_next = 1'b1;
              state_next    = S_EDGE;
            end else begin
              cmd.commit_prev = 1'b1;
              state_next      = S_IDLE;
            end
          end
        end
      end
      S_LONE: begin
        cmd.lone = 1'b1;
        m_tvalid = 1'b1;
        m_tlast  = 1'b1;
        if (m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/closed_polyline_resampler_core.sv
// Top level of the closed polyline resampler; joins controller and datapath.
// Depends on cpr_pkg, cpr_ctrl and cpr_datapath.
//
// Polygon vertices arrive as s-side beats (signed Q8.8 x and y, tlast on the
// closing vertex); resampled points leave as m-side beats, tlast on the last
// point caused by a vertex and tuser set when the edge's step count was
// clipped at MAX_STEPS. One vertex is worked at a time and s_tready is low
// meanwhile. The first vertex of a polygon is taken with no output; a lone
// closing vertex gives its one beat on the next cycle. Each edge works out
// its length, step count and per-axis division before m_tvalid rises, then
// gives one point per cycle while m_tready is high.
// step_length resets to 102 and is only to be written while idle.
module closed_polyline_resampler_core #(
  parameter int MAX_STEPS = cpr_pkg::MaxStepsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // vertex_x, vertex_y
  input  logic        s_tlast,  // closes_polygon
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // out_x, out_y
  output logic        m_tlast,  // run_end
  output logic        m_tuser   // clipped
);
  import cpr_pkg::*;

  logic [StepW-1:0]  step_length;
  cpr_cmd_t          cmd;
  cpr_stat_t         stat;
  logic [CoordW-1:0] pt_x, pt_y;
  logic              pt_clip;

  always_ff @(posedge clk) begin
    if (rst) step_length <= StepLenReset;
    else if (cfg_we) step_length <= cfg_wdata;
  end

  cpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_closes (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

  cpr_datapath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .step_length (step_length),
    .in_x        (s_tdata[15:0]),
    .in_y        (s_tdata[31:16]),
    .in_closes   (s_tlast),
    .cmd         (cmd),
    .stat        (stat),
    .pt_x        (pt_x),
    .pt_y        (pt_y),
    .pt_clip     (pt_clip)
  );

  assign m_tdata = {pt_y, pt_x};
  assign m_tuser = pt_clip;
endmodule
